// ----- hdl/lsf_pkg.sv -----
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants for the level spike filter and phase step.
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int DIST_W  = 15;
    localparam int PHASE_W = 3;
    localparam int LEVEL_W = 15;
    localparam int CFG_IDX_W = 2;
    // signed width for zero_level - 10 * level
    localparam int THR_W   = 21;

    typedef enum logic [PHASE_W-1:0] {
        PH_ZONE     = 3'd0,
        PH_CIRC     = 3'd1,
        PH_CIRC_OFF = 3'd2,
        PH_AIR      = 3'd3,
        PH_AIR_OFF  = 3'd4,
        PH_SETDOWN  = 3'd5
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPIKE_LIMIT       = 2'd0,
        REG_ZERO_LEVEL        = 2'd1,
        REG_OXYGEN_LEVEL      = 2'd2,
        REG_CIRCULATION_LEVEL = 2'd3
    } t_reg_idx;

    localparam logic [LEVEL_W-1:0] SPIKE_LIMIT_RST = 15'd20;

    typedef struct packed {
        logic [LEVEL_W-1:0] spike_limit;
        logic [LEVEL_W-1:0] zero_level;
        logic [LEVEL_W-1:0] oxygen_level;
        logic [LEVEL_W-1:0] circulation_level;
    } t_cfg;

endpackage

// ----- hdl/lsf_cfg.sv -----
// ----------------------------------------------------------------------------
// lsf_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module lsf_cfg
    import lsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEVEL_W-1:0]   i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spike_limit       <= SPIKE_LIMIT_RST;
            r_cfg.zero_level        <= '0;
            r_cfg.oxygen_level      <= '0;
            r_cfg.circulation_level <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_SPIKE_LIMIT:       r_cfg.spike_limit       <= i_cfg_data;
                REG_ZERO_LEVEL:        r_cfg.zero_level        <= i_cfg_data;
                REG_OXYGEN_LEVEL:      r_cfg.oxygen_level      <= i_cfg_data;
                REG_CIRCULATION_LEVEL: r_cfg.circulation_level <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/lsf_filter.sv -----
// ----------------------------------------------------------------------------
// lsf_filter
// Spike filter: reference distance and reject counter, updated per request.
// ----------------------------------------------------------------------------
module lsf_filter
    import lsf_pkg::*;
#(
    parameter int MAX_REJECTS = 4
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_update,
    input  logic [DIST_W-1:0]  i_distance,
    input  logic [LEVEL_W-1:0] i_spike_limit,
    output logic               o_accepted
);

    localparam int CNT_W = $clog2(MAX_REJECTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REJECTS);

    logic [DIST_W-1:0] r_ref;
    logic [DIST_W-1:0] n_ref;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [DIST_W-1:0] eff_ref;
    logic [DIST_W:0]   diff;
    logic [DIST_W-1:0] abs_diff;
    logic              spike;
    logic              reject;

    // zero reference means unset: the reading loads it
    assign eff_ref  = (r_ref == '0) ? i_distance : r_ref;
    assign diff     = {1'b0, i_distance} - {1'b0, eff_ref};
    assign abs_diff = diff[DIST_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];
    assign spike    = abs_diff > i_spike_limit;
    // a spike on a full counter is forced in
    assign reject   = spike && (r_cnt != CNT_MAX);
    assign o_accepted = !reject;

    always_comb begin
        n_ref = r_ref;
        n_cnt = r_cnt;
        if (i_update) begin
            if (reject) begin
                n_cnt = r_cnt + CNT_W'(1);
                n_ref = eff_ref;
            end else begin
                n_cnt = '0;
                n_ref = i_distance;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= '0;
            r_cnt <= '0;
        end else begin
            r_ref <= n_ref;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- hdl/lsf_phase.sv -----
// ----------------------------------------------------------------------------
// lsf_phase
// Phase step: compares the distance with the tank threshold for the phase.
// ----------------------------------------------------------------------------
module lsf_phase
    import lsf_pkg::*;
(
    input  logic [DIST_W-1:0]  i_distance,
    input  logic [PHASE_W-1:0] i_phase,
    input  logic               i_accepted,
    input  t_cfg               i_cfg,
    output logic [PHASE_W-1:0] o_next_phase
);

    logic [LEVEL_W-1:0]      level;
    logic signed [THR_W-1:0] thr;
    logic signed [THR_W-1:0] dist_s;
    logic                    below;

    always_comb begin
        case (i_phase) inside
            PH_CIRC, PH_CIRC_OFF: level = i_cfg.circulation_level;
            default:              level = i_cfg.oxygen_level;
        endcase
    end

    // zero_level - 10 * level, as (level << 3) + (level << 1)
    assign thr = $signed(THR_W'(i_cfg.zero_level))
               - $signed(THR_W'(level) << 3)
               - $signed(THR_W'(level) << 1);
    assign dist_s = $signed(THR_W'(i_distance));
    assign below  = dist_s < thr;

    always_comb begin
        o_next_phase = i_phase;
        if (i_accepted) begin
            case (i_phase) inside
                PH_ZONE:              o_next_phase = below ? PH_SETDOWN : PH_CIRC;
                PH_CIRC, PH_CIRC_OFF: if (below) o_next_phase = PH_AIR;
                PH_AIR, PH_AIR_OFF:   if (below) o_next_phase = PH_SETDOWN;
                default:              o_next_phase = i_phase;
            endcase
        end
    end

endmodule

// ----- hdl/level_spike_filter_phase_step.sv -----
// ----------------------------------------------------------------------------
// level_spike_filter_phase_step
// Spike-filtered ultrasonic level reading and plant phase step.
// ----------------------------------------------------------------------------
// One request is taken per clock while the input is not stalled. A request
// passes through the input register, then the result register, from which its
// result is offered. Throughput is one request per cycle while the result
// side does not stall. The reference distance and
// reject counter are updated as a request moves from the input register to
// the result register, which is the one place the filter state is read and
// written, so back-to-back requests see each other's updates in order.
// Configuration registers should only be written while no request is in
// flight.
module level_spike_filter_phase_step
    import lsf_pkg::*;
#(
    parameter int MAX_REJECTS = 4
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEVEL_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [DIST_W-1:0]    i_distance,
    input  logic [PHASE_W-1:0]   i_current_phase,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PHASE_W-1:0]   o_next_phase,
    output logic                 o_accepted
);

    t_cfg               cfg;
    logic               r_s1_valid;
    logic [DIST_W-1:0]  r_s1_dist;
    logic [PHASE_W-1:0] r_s1_phase;
    logic               r_out_valid;
    logic [PHASE_W-1:0] r_out_phase;
    logic               r_out_acc;
    logic               out_free;
    logic               move;
    logic               in_take;
    logic               flt_acc;
    logic [PHASE_W-1:0] nxt_phase;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    lsf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lsf_filter #(
        .MAX_REJECTS (MAX_REJECTS)
    ) u_filter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_update      (move),
        .i_distance    (r_s1_dist),
        .i_spike_limit (cfg.spike_limit),
        .o_accepted    (flt_acc)
    );

    lsf_phase u_phase (
        .i_distance   (r_s1_dist),
        .i_phase      (r_s1_phase),
        .i_accepted   (flt_acc),
        .i_cfg        (cfg),
        .o_next_phase (nxt_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (move) begin
                r_s1_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_dist  <= i_distance;
            r_s1_phase <= i_current_phase;
        end
        if (move) begin
            r_out_phase <= nxt_phase;
            r_out_acc   <= flt_acc;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_next_phase = r_out_phase;
    assign o_accepted   = r_out_acc;

endmodule

// ----- hdl/lsf_checker.sv -----
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks for level_spike_filter_phase_step, bound to the top.
// ----------------------------------------------------------------------------
module lsf_checker
    import lsf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [PHASE_W-1:0]   o_next_phase,
    input logic                 o_accepted
);

    // held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_next_phase)
                                          && $stable(o_accepted)))
        else $error("result changed while stalled");

    // input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without downstream back-pressure");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("result or stall straight after reset");

    // an accepted reading always leaves the zone phase
    a_zone_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |-> (o_next_phase != PH_ZONE))
        else $error("accepted reading reported zone phase");

endmodule

bind level_spike_filter_phase_step lsf_checker u_lsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_next_phase (o_next_phase),
    .o_accepted   (o_accepted)
);
